// ----- rtl/sorted_array_priority_queue_assert.svh -----
// Assertion macros for the sorted array priority queue.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("priority queue assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SAQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority queue assertion failed");

`endif

// ----- rtl/saq_pkg.sv -----
// Shared types and codes for the sorted array priority queue.
// No dependencies; used by the interfaces, controller, datapath and top level.
package saq_pkg;

  localparam int VAL_W = 32;
  localparam int PRI_W = 8;
  localparam int OCC_W = 5;
  localparam int ST_W  = 2;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Read address selects.
  localparam logic [2:0] RA_ZERO   = 3'd0;
  localparam logic [2:0] RA_ONE    = 3'd1;
  localparam logic [2:0] RA_IDX_M1 = 3'd2;
  localparam logic [2:0] RA_IDX_M2 = 3'd3;
  localparam logic [2:0] RA_IDX_P1 = 3'd4;

  // Write selects.
  localparam logic [1:0] WS_NEW        = 2'd0;
  localparam logic [1:0] WS_SHIFT_BACK = 2'd1;
  localparam logic [1:0] WS_SHIFT_FWD  = 2'd2;

  // Index register operations.
  localparam logic [1:0] IDX_HOLD = 2'd0;
  localparam logic [1:0] IDX_DEC  = 2'd1;
  localparam logic [1:0] IDX_INC  = 2'd2;
  localparam logic [1:0] IDX_ONE  = 2'd3;

  // Live count operations.
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [PRI_W-1:0]        prio;
  } saq_entry_t;

  typedef struct packed {
    logic            start;
    logic            rd;
    logic [2:0]      rd_sel;
    logic            wr;
    logic [1:0]      wr_sel;
    logic [1:0]      idx_op;
    logic            head_ld;
    logic            res_ld;
    logic [ST_W-1:0] res_status;
    logic [1:0]      cnt_op;
    logic            res_head;
  } saq_cmd_t;

  typedef struct packed {
    logic is_deq;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_one;
    logic le;
    logic last;
    logic cnt_one;
    logic out_free;
  } saq_stat_t;

endpackage

// ----- rtl/saq_if.sv -----
// Valid/ready channel interfaces for the priority queue request and response.
// Depends on saq_pkg for field widths.
interface saq_req_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic signed [saq_pkg::VAL_W-1:0]  item_value;
  logic [saq_pkg::PRI_W-1:0]         item_priority;

  modport source (output valid, command, item_value, item_priority, input ready);
  modport sink (input valid, command, item_value, item_priority, output ready);
endinterface

interface saq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [saq_pkg::ST_W-1:0]          status;
  logic signed [saq_pkg::VAL_W-1:0]  head_value;
  logic [saq_pkg::PRI_W-1:0]         head_priority;
  logic [saq_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, status, head_value, head_priority, occupancy, input ready);
  modport sink (input valid, status, head_value, head_priority, occupancy, output ready);
endinterface

// ----- rtl/saq_ctrl.sv -----
// Sequencer for the priority queue: walks enqueue and dequeue shifts one entry a cycle.
// Depends on saq_pkg; drives the datapath through saq_cmd_t and reads saq_stat_t.
module saq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  saq_pkg::saq_stat_t  stat,
  output saq_pkg::saq_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_ENQ_CMP   = 3'd2;
  localparam logic [2:0] S_ENQ_PUT   = 3'd3;
  localparam logic [2:0] S_DEQ_HEAD  = 3'd4;
  localparam logic [2:0] S_DEQ_SHIFT = 3'd5;
  localparam logic [2:0] S_FINISH    = 3'd6;

  logic [2:0]                state, state_next;
  logic [saq_pkg::ST_W-1:0]  fin_status, fin_status_next;
  logic [1:0]                fin_cnt, fin_cnt_next;
  logic                      fin_head, fin_head_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    fin_status <= fin_status_next;
    fin_cnt    <= fin_cnt_next;
    fin_head   <= fin_head_next;
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    fin_status_next = fin_status;
    fin_cnt_next    = fin_cnt;
    fin_head_next   = fin_head;
    cmd             = '0;
    cmd.rd_sel      = saq_pkg::RA_ZERO;
    cmd.wr_sel      = saq_pkg::WS_NEW;
    cmd.idx_op      = saq_pkg::IDX_HOLD;
    cmd.res_status  = fin_status;
    cmd.cnt_op      = fin_cnt;
    cmd.res_head    = fin_head;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat.is_deq) begin
          if (stat.full) begin
            fin_status_next = saq_pkg::ST_FULL;
            fin_cnt_next    = saq_pkg::CNT_HOLD;
            fin_head_next   = 1'b0;
            state_next      = S_FINISH;
          end else if (stat.idx_zero) begin
            cmd.wr          = 1'b1;
            cmd.wr_sel      = saq_pkg::WS_NEW;
            fin_status_next = saq_pkg::ST_DONE;
            fin_cnt_next    = saq_pkg::CNT_INC;
            fin_head_next   = 1'b0;
            state_next      = S_FINISH;
          end else begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = saq_pkg::RA_IDX_M1;
            state_next = S_ENQ_CMP;
          end
        end else begin
          if (stat.empty) begin
            fin_status_next = saq_pkg::ST_EMPTY;
            fin_cnt_next    = saq_pkg::CNT_HOLD;
            fin_head_next   = 1'b0;
            state_next      = S_FINISH;
          end else begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = saq_pkg::RA_ZERO;
            state_next = S_DEQ_HEAD;
          end
        end
      end
      S_ENQ_CMP: begin
        if (stat.le) begin
          // The entry ahead yields to the new item: move it back one slot.
          cmd.wr     = 1'b1;
          cmd.wr_sel = saq_pkg::WS_SHIFT_BACK;
          cmd.idx_op = saq_pkg::IDX_DEC;
          if (stat.idx_one) begin
            state_next = S_ENQ_PUT;
          end else begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = saq_pkg::RA_IDX_M2;
          end
        end else begin
          cmd.wr          = 1'b1;
          cmd.wr_sel      = saq_pkg::WS_NEW;
          fin_status_next = saq_pkg::ST_DONE;
          fin_cnt_next    = saq_pkg::CNT_INC;
          fin_head_next   = 1'b0;
          state_next      = S_FINISH;
        end
      end
      S_ENQ_PUT: begin
        cmd.wr          = 1'b1;
        cmd.wr_sel      = saq_pkg::WS_NEW;
        fin_status_next = saq_pkg::ST_DONE;
        fin_cnt_next    = saq_pkg::CNT_INC;
        fin_head_next   = 1'b0;
        state_next      = S_FINISH;
      end
      S_DEQ_HEAD: begin
        cmd.head_ld     = 1'b1;
        fin_status_next = saq_pkg::ST_DONE;
        fin_cnt_next    = saq_pkg::CNT_DEC;
        fin_head_next   = 1'b1;
        if (stat.cnt_one) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_sel = saq_pkg::RA_ONE;
          cmd.idx_op = saq_pkg::IDX_ONE;
          state_next = S_DEQ_SHIFT;
        end
      end
      S_DEQ_SHIFT: begin
        cmd.wr     = 1'b1;
        cmd.wr_sel = saq_pkg::WS_SHIFT_FWD;
        if (stat.last) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_sel = saq_pkg::RA_IDX_P1;
          cmd.idx_op = saq_pkg::IDX_INC;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.res_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/saq_dp.sv -----
// Datapath of the priority queue: entry memory, live count, index, item and result registers.
// Depends on saq_pkg; controlled by saq_ctrl through saq_cmd_t.
module saq_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  saq_pkg::saq_cmd_t                 cmd,
  output saq_pkg::saq_stat_t                stat,
  input  logic                              command,
  input  logic signed [saq_pkg::VAL_W-1:0]  item_value,
  input  logic [saq_pkg::PRI_W-1:0]         item_priority,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [saq_pkg::ST_W-1:0]          status,
  output logic signed [saq_pkg::VAL_W-1:0]  head_value,
  output logic [saq_pkg::PRI_W-1:0]         head_priority,
  output logic [saq_pkg::OCC_W-1:0]         occupancy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  saq_pkg::saq_entry_t mem [CAPACITY];
  saq_pkg::saq_entry_t rdata;
  saq_pkg::saq_entry_t item;
  saq_pkg::saq_entry_t head;
  saq_pkg::saq_entry_t wdata;
  logic                item_cmd;
  logic [CW-1:0]       count, count_after;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       raddr, waddr;
  logic [CW+saq_pkg::OCC_W-1:0] occ_ext;

  always_comb begin
    case (cmd.rd_sel)
      saq_pkg::RA_ONE:    raddr = ONE_C;
      saq_pkg::RA_IDX_M1: raddr = idx - ONE_C;
      saq_pkg::RA_IDX_M2: raddr = idx - CW'(2);
      saq_pkg::RA_IDX_P1: raddr = idx + ONE_C;
      default:            raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      saq_pkg::WS_SHIFT_BACK: begin
        waddr = idx;
        wdata = rdata;
      end
      saq_pkg::WS_SHIFT_FWD: begin
        waddr = idx - ONE_C;
        wdata = rdata;
      end
      default: begin
        waddr = idx;
        wdata = item;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[raddr[AW-1:0]];
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      saq_pkg::CNT_INC: count_after = count + ONE_C;
      saq_pkg::CNT_DEC: count_after = count - ONE_C;
      default:          count_after = count;
    endcase
  end

  // The occupancy field keeps the low bits of the count when the count is wider.
  assign occ_ext = {{saq_pkg::OCC_W{1'b0}}, count_after};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.res_ld) begin
        count     <= count_after;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (cmd.start) begin
      item_cmd   <= command;
      item.value <= item_value;
      item.prio  <= item_priority;
      idx        <= count;
    end else begin
      case (cmd.idx_op)
        saq_pkg::IDX_DEC: idx <= idx - ONE_C;
        saq_pkg::IDX_INC: idx <= idx + ONE_C;
        saq_pkg::IDX_ONE: idx <= ONE_C;
        default:          idx <= idx;
      endcase
    end
    if (cmd.head_ld) begin
      head <= rdata;
    end
    if (cmd.res_ld) begin
      status        <= cmd.res_status;
      head_value    <= cmd.res_head ? head.value : '0;
      head_priority <= cmd.res_head ? head.prio : '0;
      occupancy     <= occ_ext[saq_pkg::OCC_W-1:0];
    end
  end

  always_comb begin
    stat.is_deq   = (item_cmd == saq_pkg::CMD_DEQ);
    stat.full     = (count == CAP_C);
    stat.empty    = (count == '0);
    stat.idx_zero = (idx == '0);
    stat.idx_one  = (idx == ONE_C);
    stat.le       = (rdata.prio <= item.prio);
    stat.last     = ((idx + ONE_C) == count);
    stat.cnt_one  = (count == ONE_C);
    stat.out_free = !rsp_valid || rsp_ready;
  end

endmodule

// ----- rtl/sorted_array_priority_queue.sv -----
// Bounded priority queue of CAPACITY entries kept sorted by priority, highest first, in an
// entry memory with one registered read port and one write port. One request is handled at
// a time. A rejected request, or an enqueue into an empty queue, goes from dispatch to the
// finish state; any other enqueue compares the entries ahead of the new item in turn and
// moves back each one of lower or equal priority before the item is written; a dequeue
// reads the head and then shifts the remaining live entries forward. In the finish state,
// a result still held in the output register delays the load until rsp.ready. The queue
// is ready again in the cycle after the load. Shifts are paced by the entry memory, which
// moves one entry per cycle. A finished result waits in the output register while the
// next request is accepted.
module sorted_array_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  saq_req_if.sink    req,
  saq_rsp_if.source  rsp
);

  saq_pkg::saq_cmd_t  cmd;
  saq_pkg::saq_stat_t stat;

  saq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  saq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .command       (req.command),
    .item_value    (req.item_value),
    .item_priority (req.item_priority),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .head_value    (rsp.head_value),
    .head_priority (rsp.head_priority),
    .occupancy     (rsp.occupancy)
  );

`include "sorted_array_priority_queue_assert.svh"

  `SAQ_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready)
  `SAQ_ASSERT_NOW(a_load_when_free, cmd.res_ld, stat.out_free)
  `SAQ_ASSERT_NOW(a_reject_no_head, rsp.valid && (rsp.status != saq_pkg::ST_DONE),
                  (rsp.head_value == '0) && (rsp.head_priority == '0))
  `SAQ_ASSERT_NOW(a_no_mem_in_finish, cmd.res_ld, !cmd.wr && !cmd.rd)

endmodule
